[hw/rtl/value_noise_fbm_top_macros.svh]
// Assertion macros shared by the value noise fBm checker.
`ifndef VALUE_NOISE_FBM_TOP_MACROS_SVH
`define VALUE_NOISE_FBM_TOP_MACROS_SVH

// Property checked at every clock edge, skipped while reset is held.
`define VNF_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define VNF_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/vnf_pkg.sv]
// Shared types and constants of the value noise fBm block.
package vnf_pkg;

  localparam int COORD_W = 28;
  localparam int NOISE_W = 16;
  localparam int SEED_W  = 32;
  localparam int CNT_W   = 4;
  localparam int IDX_W   = 4;

  localparam logic [IDX_W-1:0] CFG_NOISE_SEED   = 4'd0;
  localparam logic [IDX_W-1:0] CFG_OCTAVE_COUNT = 4'd1;

  localparam logic [CNT_W-1:0] OCTAVE_COUNT_RST = 4'd4;

  localparam logic [31:0] HASH_KX   = 32'd374761393;
  localparam logic [31:0] HASH_KY   = 32'd668265263;
  localparam logic [31:0] HASH_KS   = 32'd2246822519;
  localparam logic [31:0] HASH_KMIX = 32'd1274126177;

  typedef struct packed {
    logic [SEED_W-1:0] seed;
    logic [CNT_W-1:0]  oct_cnt;
  } cfg_t;

  // What one cell hands to the next: the item, its coordinates and partial sum.
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [NOISE_W-1:0] sum;
  } link_t;

  function automatic logic [31:0] mix_shift13(input logic [31:0] s);
    return s ^ (s >> 13);
  endfunction

  function automatic logic [NOISE_W-1:0] fold16(input logic [31:0] m);
    logic [31:0] t;
    t = m ^ (m >> 16);
    return t[NOISE_W-1:0];
  endfunction

endpackage

[hw/rtl/vnf_cell.sv]
// One octave cell: lattice hash, smoothstep and bilinear blend, adds to the sum.
module vnf_cell #(
  parameter int IDX       = 0,
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  vnf_pkg::cfg_t  cfg,
  input  vnf_pkg::link_t lnk_in,
  output vnf_pkg::link_t lnk_out
);
  import vnf_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int PXW  = F + 32;
  localparam int DLY  = 8;
  localparam logic [F:0]   ONE_FIX   = (F+1)'(1) << F;
  localparam logic [F+1:0] THREE_FIX = (F+2)'(3) << F;

  link_t dly_r [DLY];
  link_t out_r;

  // stage 1 extraction
  logic [PXW-1:0] px, py;
  logic [F-1:0]   fx, fy;
  logic [31:0]    ix, iy;
  logic [2*F-1:0] fxx, fyy;

  assign px  = PXW'(lnk_in.coord_x) << IDX;
  assign py  = PXW'(lnk_in.coord_y) << IDX;
  assign fx  = px[F-1:0];
  assign fy  = py[F-1:0];
  assign ix  = px[PXW-1:F];
  assign iy  = py[PXW-1:F];
  assign fxx = fx * fx;
  assign fyy = fy * fy;

  logic [31:0]  pkx1_r, pky1_r, sd1_r;
  logic [F-1:0] f2x1_r, f2y1_r, fx1_r, fy1_r;

  // stage 2: seed product and smoothstep
  logic [2*F+1:0] smx, smy;
  assign smx = f2x1_r * (THREE_FIX - {1'b0, fx1_r, 1'b0});
  assign smy = f2y1_r * (THREE_FIX - {1'b0, fy1_r, 1'b0});

  logic [31:0] pkx2_r, pky2_r, sk2_r;
  logic [F:0]  sx2_r, sy2_r;

  // stage 3: corner sums and first mix
  logic [31:0] base;
  logic [31:0] csum [4];
  assign base    = pkx2_r + pky2_r + sk2_r;
  assign csum[0] = base;
  assign csum[1] = base + HASH_KX;
  assign csum[2] = base + HASH_KY;
  assign csum[3] = base + HASH_KX + HASH_KY;

  logic [31:0]        h3_r [4];
  logic [31:0]        m4_r [4];
  logic [NOISE_W-1:0] hv5_r [4];
  logic [F:0]         sx3_r, sy3_r, sx4_r, sy4_r, sx5_r, sy5_r, sy6_r, sy7_r;

  // blend
  logic [F+16:0] pa6_r, pb6_r, pc6_r, pd6_r;
  logic [F+17:0] row0, row1;
  logic [NOISE_W-1:0] r07_r, r17_r;
  logic [F+16:0] q08_r, q18_r;
  logic [F+17:0] vsum;
  logic [NOISE_W-1:0] v, v_sh;
  logic en;

  assign row0 = {1'b0, pa6_r} + {1'b0, pb6_r};
  assign row1 = {1'b0, pc6_r} + {1'b0, pd6_r};
  assign vsum = {1'b0, q08_r} + {1'b0, q18_r};
  assign v    = vsum[F+15:F];
  assign v_sh = v >> (IDX + 1);
  assign en   = {28'd0, cfg.oct_cnt} > 32'(IDX);

  always_ff @(posedge clk) begin
    if (adv) begin
      pkx1_r <= ix * HASH_KX;
      pky1_r <= iy * HASH_KY;
      sd1_r  <= cfg.seed + 32'(IDX);
      f2x1_r <= fxx[2*F-1:F];
      f2y1_r <= fyy[2*F-1:F];
      fx1_r  <= fx;
      fy1_r  <= fy;

      pkx2_r <= pkx1_r;
      pky2_r <= pky1_r;
      sk2_r  <= sd1_r * HASH_KS;
      sx2_r  <= smx[2*F:F];
      sy2_r  <= smy[2*F:F];

      for (int c = 0; c < 4; c++) begin
        h3_r[c]  <= mix_shift13(csum[c]);
        m4_r[c]  <= h3_r[c] * HASH_KMIX;
        hv5_r[c] <= fold16(m4_r[c]);
      end
      sx3_r <= sx2_r;
      sy3_r <= sy2_r;
      sx4_r <= sx3_r;
      sy4_r <= sy3_r;
      sx5_r <= sx4_r;
      sy5_r <= sy4_r;

      pa6_r <= hv5_r[0] * (ONE_FIX - sx5_r);
      pb6_r <= hv5_r[1] * sx5_r;
      pc6_r <= hv5_r[2] * (ONE_FIX - sx5_r);
      pd6_r <= hv5_r[3] * sx5_r;
      sy6_r <= sy5_r;

      r07_r <= row0[F+15:F];
      r17_r <= row1[F+15:F];
      sy7_r <= sy6_r;

      q08_r <= r07_r * (ONE_FIX - sy7_r);
      q18_r <= r17_r * sy7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DLY; k++) begin
        dly_r[k] <= '0;
      end
      out_r <= '0;
    end else if (adv) begin
      dly_r[0] <= lnk_in;
      for (int k = 1; k < DLY; k++) begin
        dly_r[k] <= dly_r[k-1];
      end
      out_r.valid   <= dly_r[DLY-1].valid;
      out_r.coord_x <= dly_r[DLY-1].coord_x;
      out_r.coord_y <= dly_r[DLY-1].coord_y;
      out_r.sum     <= dly_r[DLY-1].sum + (en ? v_sh : '0);
    end
  end

  assign lnk_out = out_r;

endmodule

[hw/rtl/value_noise_fbm_top.sv]
// Top level of the value noise fBm block: config registers and the octave cell chain.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid in_ready in_coord_x in_coord_y | sink
//  out     | out_valid out_ready out_noise_value     | source
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data  | sink
//
// One item enters per cycle unless the output stalls; each cell is 9 stages deep.
// The last cell's sum register is the output register. A stalled output
// freezes the whole chain and drops in_ready until out_ready returns.
// Reset clears valid bits, seed (0) and octave count (4); cfg_ready is always high.
module value_noise_fbm_top #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vnf_pkg::COORD_W-1:0]   in_coord_x,
  input  logic [vnf_pkg::COORD_W-1:0]   in_coord_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vnf_pkg::NOISE_W-1:0]   out_noise_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vnf_pkg::IDX_W-1:0]     cfg_index,
  input  logic [vnf_pkg::SEED_W-1:0]    cfg_data
);
  import vnf_pkg::*;

  cfg_t  cfg_r;
  link_t lnk [MAX_OCTAVES+1];
  logic  adv;

  // Advance whenever the output register is empty or being drained.
  assign adv       = !lnk[MAX_OCTAVES].valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seed    <= '0;
      cfg_r.oct_cnt <= OCTAVE_COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NOISE_SEED:   cfg_r.seed    <= cfg_data;
        CFG_OCTAVE_COUNT: cfg_r.oct_cnt <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Head of the chain: a fresh item with an empty sum.
  assign lnk[0].valid   = in_valid && in_ready;
  assign lnk[0].coord_x = in_coord_x;
  assign lnk[0].coord_y = in_coord_y;
  assign lnk[0].sum     = '0;

  // One cell per octave; cells beyond the configured count pass the sum on.
  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_cell
    vnf_cell #(
      .IDX       (g),
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .cfg     (cfg_r),
      .lnk_in  (lnk[g]),
      .lnk_out (lnk[g+1])
    );
  end

  assign out_valid       = lnk[MAX_OCTAVES].valid;
  assign out_noise_value = lnk[MAX_OCTAVES].sum;

endmodule

[hw/rtl/value_noise_fbm_chk.sv]
// Port-level checker for the value noise fBm top level, with its bind.
`include "value_noise_fbm_top_macros.svh"

module value_noise_fbm_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [vnf_pkg::COORD_W-1:0] in_coord_x,
  input logic [vnf_pkg::COORD_W-1:0] in_coord_y,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [vnf_pkg::NOISE_W-1:0] out_noise_value,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [vnf_pkg::IDX_W-1:0]   cfg_index,
  input logic [vnf_pkg::SEED_W-1:0]  cfg_data
);

  logic out_stall;
  assign out_stall = out_valid && !out_ready;

  // No result may be left over from before reset.
  `VNF_ASSERT_ALL(a_rst_empty, !rst_n |=> !out_valid, "result valid right after reset")

  // Hold a stalled result and its value.
  `VNF_ASSERT_RUN(a_out_hold, out_stall |=> out_valid && $stable(out_noise_value), "result moved")

  // Drop input ready only on an output stall.
  `VNF_ASSERT_RUN(a_ready_stall, !in_ready |-> out_stall, "input blocked without an output stall")

  // Register writes are never held off.
  `VNF_ASSERT_RUN(a_cfg_ready, cfg_valid |-> cfg_ready, "config write held off")

endmodule

bind value_noise_fbm_top value_noise_fbm_chk u_vnf_chk (.*);

[tb/value_noise_fbm_top_test.sv]
// Self-checking testbench of the value noise fBm block.
`timescale 1ns / 1ps

module value_noise_fbm_top_test;
  import vnf_pkg::*;

  localparam int MAX_OCT   = 8;
  localparam int FRAC      = 16;
  localparam int LATENCY   = 9 * MAX_OCT;
  localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};
  // Index with no register behind it; a write to it must change nothing.
  localparam logic [IDX_W-1:0] CFG_UNUSED = 4'd9;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [COORD_W-1:0]  in_coord_x;
  logic [COORD_W-1:0]  in_coord_y;
  logic                out_valid;
  logic                out_ready;
  logic [NOISE_W-1:0]  out_noise_value;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index;
  logic [SEED_W-1:0]   cfg_data;

  value_noise_fbm_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .out_valid(out_valid), .out_ready(out_ready), .out_noise_value(out_noise_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor's own copy of the registers.
  logic [SEED_W-1:0] seed_q;
  logic [CNT_W-1:0]  oct_q;

  logic [NOISE_W-1:0] noise_expected[$];
  bit                 failed = 1'b0;
  bit                 quiet;  // no-idle stretch on both sides

  // Directed stimulus; chk marks a result known at a glance.
  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    bit                 chk;
    logic [NOISE_W-1:0] val;
  } point_row_t;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [15:0] corner_hash(logic [31:0] cx, logic [31:0] cy,
                                              logic [31:0] sd);
    logic [31:0] h;
    h = cx * HASH_KX + cy * HASH_KY + sd * HASH_KS;
    h = (h ^ (h >> 13)) * HASH_KMIX;
    h = h ^ (h >> 16);
    return h[15:0];
  endfunction

  function automatic logic [63:0] smoothstep_fix(logic [63:0] f);
    logic [63:0] f2;
    f2 = (f * f) >> FRAC;
    return (f2 * (3 * (64'd1 << FRAC) - 2 * f)) >> FRAC;
  endfunction

  function automatic logic [63:0] octave_noise(logic [63:0] px, logic [63:0] py,
                                               logic [31:0] sd);
    logic [63:0] one, sx, sy, a, b, c, d, r0, r1;
    logic [31:0] ix, iy;
    one = 64'd1 << FRAC;
    ix = px[FRAC +: 32];
    iy = py[FRAC +: 32];
    sx = smoothstep_fix(px & (one - 1));
    sy = smoothstep_fix(py & (one - 1));
    a = 64'(corner_hash(ix, iy, sd));
    b = 64'(corner_hash(ix + 32'd1, iy, sd));
    c = 64'(corner_hash(ix, iy + 32'd1, sd));
    d = 64'(corner_hash(ix + 32'd1, iy + 32'd1, sd));
    r0 = (a * (one - sx) + b * sx) >> FRAC;
    r1 = (c * (one - sx) + d * sx) >> FRAC;
    return (r0 * (one - sy) + r1 * sy) >> FRAC;
  endfunction

  function automatic logic [NOISE_W-1:0] fbm_noise(logic [COORD_W-1:0] x,
                                                   logic [COORD_W-1:0] y);
    int unsigned n;
    logic [63:0] total;
    n = (oct_q > MAX_OCT) ? MAX_OCT : oct_q;
    total = '0;
    for (int unsigned i = 0; i < n; i++)
      total += octave_noise(64'(x) << i, 64'(y) << i, seed_q + i) >> (i + 1);
    return total[NOISE_W-1:0];
  endfunction

  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < 13);
  endfunction

  // Write one register; only called with nothing in flight.
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [SEED_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_NOISE_SEED) seed_q = data;
    else if (idx == CFG_OCTAVE_COUNT) oct_q = data[CNT_W-1:0];
    @(posedge clk);
  endtask

  // Offer one item, queue its expectation on acceptance.
  task automatic send_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            bit chk, logic [NOISE_W-1:0] val);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_coord_x <= x;
    in_coord_y <= y;
    do @(posedge clk); while (!in_ready);
    noise_expected.push_back(chk ? val : fbm_noise(x, y));
  endtask

  // Wait until every result is back, then let the pipe drain.
  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (noise_expected.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (noise_expected.size() != 0) begin
      $display("*** FAILED ***");
      $finish;
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic random_points(int count);
    logic [COORD_W-1:0] x, y;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(3))
        0: begin  // small coordinates, where lattice and octaves are dense
          x = COORD_W'($urandom_range(32'h3FFFF));
          y = COORD_W'($urandom_range(32'h3FFFF));
        end
        1: begin  // near the top, where corners wrap once shifted
          x = COORD_W'(COORD_MAX - $urandom_range(32'h1FFFF));
          y = COORD_W'(COORD_MAX - $urandom_range(32'h1FFFF));
        end
        default: begin
          x = COORD_W'($urandom());
          y = COORD_W'($urandom());
        end
      endcase
      send_point(x, y, 1'b0, '0);
    end
  endtask

  // Result side: random stalls and checking.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (noise_expected.size() == 0) begin
          $display("%0t: unexpected item, actual %h", $time, out_noise_value);
          failed <= 1'b1;
        end else begin
          if (noise_expected[0] !== out_noise_value) begin
            $display("%0t: noise_value expected %h actual %h",
                     $time, noise_expected[0], out_noise_value);
            failed <= 1'b1;
          end
          void'(noise_expected.pop_front());
        end
      end
      out_ready <= !idle_now();
    end
  end

  initial begin
    point_row_t rows[$];
    quiet      = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_coord_x = '0;
    in_coord_y = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_NOISE_SEED;
    cfg_data   = '0;
    seed_q     = '0;
    oct_q      = OCTAVE_COUNT_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, lattice points, corner wrap, reset settings.
    rows = '{
      '{'0, '0, 1'b0, '0},
      '{COORD_MAX, COORD_MAX, 1'b0, '0},
      '{COORD_MAX, '0, 1'b0, '0},
      '{'0, COORD_MAX, 1'b0, '0},
      '{28'h0010000, 28'h0020000, 1'b0, '0},
      '{28'h000FFFF, 28'h000FFFF, 1'b0, '0},
      '{28'h0008000, 28'h0008000, 1'b0, '0},
      '{28'hAAAAAAA, 28'h5555555, 1'b0, '0},
      '{28'h5555555, 28'hAAAAAAA, 1'b0, '0},
      '{28'h8000000, 28'h8000000, 1'b0, '0}
    };
    foreach (rows[r]) send_point(rows[r].x, rows[r].y, rows[r].chk, rows[r].val);
    drain();

    // Zero octaves: result is zero whatever the point.
    write_reg(CFG_OCTAVE_COUNT, 32'd0);
    send_point(COORD_MAX, COORD_MAX, 1'b1, '0);
    send_point(28'h1234567, 28'h7654321, 1'b1, '0);
    drain();

    // Seed wrap with the most octaves; count above the limit; unknown index.
    write_reg(CFG_NOISE_SEED, 32'hFFFF_FFFD);
    write_reg(CFG_OCTAVE_COUNT, 32'd15);
    write_reg(CFG_UNUSED, 32'h0000_0001);
    foreach (rows[r]) send_point(rows[r].x, rows[r].y, 1'b0, '0);
    drain();

    // Random phases over several settings, one without idling.
    write_reg(CFG_OCTAVE_COUNT, 32'd1);
    write_reg(CFG_NOISE_SEED, 32'h0);
    random_points(200);
    drain();
    write_reg(CFG_OCTAVE_COUNT, 32'd8);
    write_reg(CFG_NOISE_SEED, 32'hFFFF_FFFF);
    random_points(300);
    drain();
    quiet = 1'b1;
    write_reg(CFG_OCTAVE_COUNT, 32'd9);
    write_reg(CFG_NOISE_SEED, $urandom());
    random_points(300);
    drain();
    quiet = 1'b0;
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_OCTAVE_COUNT, $urandom_range(15));
      write_reg(CFG_NOISE_SEED, $urandom());
      random_points(150);
      drain();
    end

    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/vnf_pkg.sv
hw/rtl/vnf_cell.sv
hw/rtl/value_noise_fbm_top.sv
hw/rtl/value_noise_fbm_chk.sv
tb/value_noise_fbm_top_test.sv
